[rtl/ffa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and constants of the first-fit allocator with nur eviction
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int TIME_WIDTH_DEF = 16;

  localparam logic [15:0] MEM_SIZE_RST = 16'd1024;
  localparam logic [7:0]  PERIOD_RST   = 8'd10;
  localparam logic [1:0]  CLS_OWNED    = 2'd3;

  typedef enum logic [1:0] {
    OPC_ALLOC = 2'd0,
    OPC_REF   = 2'd1,
    OPC_TICK  = 2'd2,
    OPC_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_PLACED     = 3'd0,
    ST_EVICTED    = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_REF_DONE   = 3'd4,
    ST_NOT_RES    = 3'd5,
    ST_TICK_DONE  = 3'd6
  } status_t;

  typedef enum logic [0:0] {
    CFG_MEM_SIZE     = 1'b0,
    CFG_CLOCK_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SCAN_START,
    OP_FIT_STEP,
    OP_EVS_STEP,
    OP_IDX_BEST,
    OP_PLACE,
    OP_EVICT_LOAD,
    OP_MERGE_PREV,
    OP_MERGE_NEXT,
    OP_REF,
    OP_TICK
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    latch;
    logic    emit;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic fit_hit;
    logic ref_hit;
    logic needs_split;
    logic full;
    logic best_found;
    logic req_zero;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/ffa_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_dp
// block table, scan pointer, time base, config registers and result register
// ----------------------------------------------------------------------------
module ffa_dp import ffa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       st,
  input  wire logic [7:0]  in_process_id,
  input  wire logic [15:0] in_request_size,
  input  wire logic        in_referenced,
  input  wire logic        in_modified,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic [2:0]       out_status,
  output logic [7:0]       out_result_id,
  output logic [15:0]      out_start_address,
  output logic [1:0]       out_nur_class,
  output logic             out_last
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  // table columns
  logic [15:0]           bst_r  [MAX_BLOCKS];
  logic [15:0]           bsz_r  [MAX_BLOCKS];
  logic                  bus_r  [MAX_BLOCKS];
  logic [7:0]            bpid_r [MAX_BLOCKS];
  logic                  br_r   [MAX_BLOCKS];
  logic                  bm_r   [MAX_BLOCKS];
  logic [TIME_WIDTH-1:0] bmt_r  [MAX_BLOCKS];
  logic [15:0]           bst_nxt  [MAX_BLOCKS];
  logic [15:0]           bsz_nxt  [MAX_BLOCKS];
  logic                  bus_nxt  [MAX_BLOCKS];
  logic [7:0]            bpid_nxt [MAX_BLOCKS];
  logic                  br_nxt   [MAX_BLOCKS];
  logic                  bm_nxt   [MAX_BLOCKS];
  logic [TIME_WIDTH-1:0] bmt_nxt  [MAX_BLOCKS];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] best_idx_r, best_idx_nxt;
  logic [1:0]    best_cls_r, best_cls_nxt;
  logic          best_found_r, best_found_nxt;
  logic [15:0]   w_st_r, w_st_nxt, w_sz_r, w_sz_nxt;
  logic [TIME_WIDTH-1:0] time_r, time_nxt;
  logic [7:0]    phase_r, phase_nxt;
  logic [7:0]    period_r;
  logic [7:0]    pid_r;
  logic [15:0]   req_r;
  logic          rf_r, md_r;

  // single read port at the scan pointer
  logic [15:0]           rd_st, rd_sz;
  logic                  rd_used, rd_rb, rd_mb;
  logic [7:0]            rd_pid;
  logic [1:0]            rd_cls;
  logic                  prev_free, next_free, sweep;
  logic [TIME_WIDTH-1:0] time_inc;
  logic [7:0]            phase_inc;

  assign rd_st   = bst_r[idx_r[AW-1:0]];
  assign rd_sz   = bsz_r[idx_r[AW-1:0]];
  assign rd_used = bus_r[idx_r[AW-1:0]];
  assign rd_pid  = bpid_r[idx_r[AW-1:0]];
  assign rd_rb   = br_r[idx_r[AW-1:0]];
  assign rd_mb   = bm_r[idx_r[AW-1:0]];
  assign rd_cls  = {rd_rb, rd_mb};

  assign st.in_range    = idx_r < cnt_r;
  assign st.fit_hit     = st.in_range && !rd_used && (rd_sz >= req_r);
  assign st.ref_hit     = st.in_range && rd_used && (rd_pid == pid_r);
  assign st.needs_split = rd_sz > req_r;
  assign st.full        = cnt_r >= CNT_MAX;
  assign st.best_found  = best_found_r;
  assign st.req_zero    = req_r == 16'd0;

  assign prev_free = (pos_r != '0) && !rd_used;
  assign next_free = st.in_range && !rd_used;
  assign time_inc  = time_r + TIME_WIDTH'(1);
  assign phase_inc = phase_r + 8'd1;
  assign sweep     = phase_inc >= period_r;

  always_comb begin
    bst_nxt  = bst_r;
    bsz_nxt  = bsz_r;
    bus_nxt  = bus_r;
    bpid_nxt = bpid_r;
    br_nxt   = br_r;
    bm_nxt   = bm_r;
    bmt_nxt  = bmt_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    best_idx_nxt   = best_idx_r;
    best_cls_nxt   = best_cls_r;
    best_found_nxt = best_found_r;
    w_st_nxt       = w_st_r;
    w_sz_nxt       = w_sz_r;
    time_nxt       = time_r;
    phase_nxt      = phase_r;
    case (cmd.op)
      OP_SCAN_START: begin
        idx_nxt        = '0;
        best_found_nxt = 1'b0;
      end
      OP_FIT_STEP: idx_nxt = idx_r + CW'(1);
      OP_EVS_STEP: begin
        idx_nxt = idx_r + CW'(1);
        if (st.in_range && rd_used && (!best_found_r || rd_cls < best_cls_r)) begin
          best_found_nxt = 1'b1;
          best_cls_nxt   = rd_cls;
          best_idx_nxt   = idx_r;
        end
      end
      OP_IDX_BEST: idx_nxt = best_idx_r;
      OP_PLACE: begin
        for (int j = 0; j < MAX_BLOCKS; j++) begin
          if (j == int'(idx_r)) begin
            if (st.needs_split) bsz_nxt[j] = req_r;
            bus_nxt[j]  = 1'b1;
            bpid_nxt[j] = pid_r;
            br_nxt[j]   = 1'b1;
            bm_nxt[j]   = 1'b1;
            bmt_nxt[j]  = time_r;
          end else if (st.needs_split && j == int'(idx_r) + 1) begin
            bst_nxt[j]  = rd_st + req_r;
            bsz_nxt[j]  = rd_sz - req_r;
            bus_nxt[j]  = 1'b0;
            bpid_nxt[j] = 8'd0;
            br_nxt[j]   = 1'b0;
            bm_nxt[j]   = 1'b0;
            bmt_nxt[j]  = '0;
          end else if (st.needs_split && j > int'(idx_r) + 1) begin
            bst_nxt[j]  = bst_r[j-1];
            bsz_nxt[j]  = bsz_r[j-1];
            bus_nxt[j]  = bus_r[j-1];
            bpid_nxt[j] = bpid_r[j-1];
            br_nxt[j]   = br_r[j-1];
            bm_nxt[j]   = bm_r[j-1];
            bmt_nxt[j]  = bmt_r[j-1];
          end
        end
        if (st.needs_split) cnt_nxt = cnt_r + CW'(1);
      end
      OP_EVICT_LOAD: begin
        w_st_nxt = rd_st;
        w_sz_nxt = rd_sz;
        pos_nxt  = idx_r;
        idx_nxt  = idx_r - CW'(1);
      end
      OP_MERGE_PREV: begin
        for (int j = 0; j < MAX_BLOCKS; j++) begin
          if (prev_free && j == int'(pos_r) - 1) begin
            bsz_nxt[j] = rd_sz + w_sz_r;
          end else if (prev_free && j >= int'(pos_r) && j < MAX_BLOCKS - 1) begin
            bst_nxt[j]  = bst_r[j+1];
            bsz_nxt[j]  = bsz_r[j+1];
            bus_nxt[j]  = bus_r[j+1];
            bpid_nxt[j] = bpid_r[j+1];
            br_nxt[j]   = br_r[j+1];
            bm_nxt[j]   = bm_r[j+1];
            bmt_nxt[j]  = bmt_r[j+1];
          end else if (!prev_free && j == int'(pos_r)) begin
            bst_nxt[j]  = w_st_r;
            bsz_nxt[j]  = w_sz_r;
            bus_nxt[j]  = 1'b0;
            bpid_nxt[j] = 8'd0;
            br_nxt[j]   = 1'b0;
            bm_nxt[j]   = 1'b0;
            bmt_nxt[j]  = '0;
          end
        end
        if (prev_free) begin
          w_st_nxt = rd_st;
          w_sz_nxt = rd_sz + w_sz_r;
          pos_nxt  = pos_r - CW'(1);
          idx_nxt  = pos_r;
          cnt_nxt  = cnt_r - CW'(1);
        end else begin
          idx_nxt = pos_r + CW'(1);
        end
      end
      OP_MERGE_NEXT: begin
        for (int j = 0; j < MAX_BLOCKS; j++) begin
          if (j == int'(pos_r)) begin
            bst_nxt[j]  = w_st_r;
            bsz_nxt[j]  = next_free ? w_sz_r + rd_sz : w_sz_r;
            bus_nxt[j]  = 1'b0;
            bpid_nxt[j] = 8'd0;
            br_nxt[j]   = 1'b0;
            bm_nxt[j]   = 1'b0;
            bmt_nxt[j]  = '0;
          end else if (next_free && j >= int'(idx_r) && j < MAX_BLOCKS - 1) begin
            bst_nxt[j]  = bst_r[j+1];
            bsz_nxt[j]  = bsz_r[j+1];
            bus_nxt[j]  = bus_r[j+1];
            bpid_nxt[j] = bpid_r[j+1];
            br_nxt[j]   = br_r[j+1];
            bm_nxt[j]   = bm_r[j+1];
            bmt_nxt[j]  = bmt_r[j+1];
          end
        end
        if (next_free) cnt_nxt = cnt_r - CW'(1);
        idx_nxt = '0;
      end
      OP_REF: begin
        for (int j = 0; j < MAX_BLOCKS; j++) begin
          if (j == int'(idx_r)) begin
            if (rf_r) br_nxt[j] = 1'b1;
            if (md_r && !bm_r[j]) begin
              bm_nxt[j]  = 1'b1;
              bmt_nxt[j] = time_r;
            end
          end
        end
      end
      OP_TICK: begin
        time_nxt  = time_inc;
        phase_nxt = sweep ? 8'd0 : phase_inc;
        if (sweep) begin
          for (int j = 0; j < MAX_BLOCKS; j++) begin
            if (bus_r[j]) begin
              br_nxt[j] = 1'b0;
              if (bm_r[j] && ((time_inc - bmt_r[j]) >= TIME_WIDTH'(period_r)))
                bm_nxt[j] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    // new memory size: table back to one free block
    if (cfg_we && cfg_index == CFG_MEM_SIZE) begin
      bst_nxt[0] = 16'd0;
      bsz_nxt[0] = cfg_data;
      bus_nxt[0] = 1'b0;
      cnt_nxt    = CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    bpid_r <= bpid_nxt;
    br_r   <= br_nxt;
    bm_r   <= bm_nxt;
    bmt_r  <= bmt_nxt;
    if (!rst_n) begin
      bus_r[0] <= 1'b0;
      bst_r[0] <= 16'd0;
      bsz_r[0] <= MEM_SIZE_RST;
    end else begin
      bus_r <= bus_nxt;
      bst_r <= bst_nxt;
      bsz_r <= bsz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= CW'(1);
      idx_r        <= '0;
      pos_r        <= '0;
      best_found_r <= 1'b0;
      time_r       <= '0;
      phase_r      <= 8'd0;
      period_r     <= PERIOD_RST;
    end else begin
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      pos_r        <= pos_nxt;
      best_found_r <= best_found_nxt;
      time_r       <= time_nxt;
      phase_r      <= phase_nxt;
      if (cfg_we && cfg_index == CFG_CLOCK_PERIOD) period_r <= cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_cls_r <= best_cls_nxt;
    w_st_r     <= w_st_nxt;
    w_sz_r     <= w_sz_nxt;
    if (cmd.latch) begin
      pid_r <= in_process_id;
      req_r <= in_request_size;
      rf_r  <= in_referenced;
      md_r  <= in_modified;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.code;
      case (cmd.code)
        ST_PLACED: begin
          out_result_id     <= pid_r;
          out_start_address <= rd_st;
          out_nur_class     <= CLS_OWNED;
          out_last          <= 1'b1;
        end
        ST_EVICTED: begin
          out_result_id     <= rd_pid;
          out_start_address <= rd_st;
          out_nur_class     <= rd_cls;
          out_last          <= 1'b0;
        end
        ST_REF_DONE: begin
          out_result_id     <= pid_r;
          out_start_address <= rd_st;
          out_nur_class     <= {rd_rb | rf_r, rd_mb | md_r};
          out_last          <= 1'b1;
        end
        ST_TICK_DONE: begin
          out_result_id     <= 8'd0;
          out_start_address <= 16'd0;
          out_nur_class     <= 2'd0;
          out_last          <= 1'b1;
        end
        default: begin
          out_result_id     <= pid_r;
          out_start_address <= 16'd0;
          out_nur_class     <= 2'd0;
          out_last          <= 1'b1;
        end
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && cnt_r <= CNT_MAX)
    else $error("block count out of range");

  a_split_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_PLACE && st.needs_split && !cfg_we |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("split did not grow the table");

  a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_MERGE_NEXT && next_free && !cfg_we |=> cnt_r == $past(cnt_r) - CW'(1))
    else $error("merge did not shrink the table");

endmodule
`default_nettype wire

[rtl/ffa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer for allocate, reference and tick items; owns the result valid
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_opcode,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            cfg_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t st
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIT, S_PLACE, S_EVSCAN, S_EVLOAD, S_MPREV, S_MNEXT, S_RFIND, S_TICK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.latch = 1'b0;
    cmd.emit  = 1'b0;
    cmd.code  = ST_NO_SPACE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.op    = OP_SCAN_START;
          case (in_opcode)
            OPC_ALLOC: state_nxt = S_FIT;
            OPC_REF:   state_nxt = S_RFIND;
            OPC_TICK:  state_nxt = S_TICK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIT: begin
        if (st.req_zero) begin
          if (slot_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (!st.in_range) begin
          cmd.op    = OP_SCAN_START;
          state_nxt = S_EVSCAN;
        end else if (st.fit_hit) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.op = OP_FIT_STEP;
        end
      end
      S_PLACE: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
          if (st.needs_split && st.full) begin
            cmd.code = ST_TABLE_FULL;
          end else begin
            cmd.code = ST_PLACED;
            cmd.op   = OP_PLACE;
          end
        end
      end
      S_EVSCAN: begin
        if (st.in_range) begin
          cmd.op = OP_EVS_STEP;
        end else if (!st.best_found) begin
          if (slot_free) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op    = OP_IDX_BEST;
          state_nxt = S_EVLOAD;
        end
      end
      S_EVLOAD: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_EVICTED;
          cmd.op    = OP_EVICT_LOAD;
          state_nxt = S_MPREV;
        end
      end
      S_MPREV: begin
        cmd.op    = OP_MERGE_PREV;
        state_nxt = S_MNEXT;
      end
      S_MNEXT: begin
        cmd.op    = OP_MERGE_NEXT;
        state_nxt = S_FIT;
      end
      S_RFIND: begin
        if (!st.in_range) begin
          if (slot_free) begin
            cmd.emit  = 1'b1;
            cmd.code  = ST_NOT_RES;
            state_nxt = S_IDLE;
          end
        end else if (st.ref_hit) begin
          if (slot_free) begin
            cmd.emit  = 1'b1;
            cmd.code  = ST_REF_DONE;
            cmd.op    = OP_REF;
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.op = OP_FIT_STEP;
        end
      end
      S_TICK: begin
        if (slot_free) begin
          cmd.emit  = 1'b1;
          cmd.code  = ST_TICK_DONE;
          cmd.op    = OP_TICK;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free)
    else $error("result overwritten before taken");

  a_busy_no_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !cfg_ready && !in_ready)
    else $error("ports open while busy");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result beat dropped while stalled");

endmodule
`default_nettype wire

[rtl/first_fit_allocator_nur_eviction.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_allocator_nur_eviction
// first-fit block allocator over an address-ordered table with nur eviction
// ----------------------------------------------------------------------------
// throughput: one item at a time, set by the single-port table walk; a
//   waiting result beat holds the sequencer until out_ready
// reset: synchronous active low; table becomes one free block of 1024
//   units, time and phase zero, clock period 10; no clearing pass
module first_fit_allocator_nur_eviction import ffa_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_process_id,
  input  wire logic [15:0] in_request_size,
  input  wire logic        in_referenced,
  input  wire logic        in_modified,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_result_id,
  output logic [15:0]      out_start_address,
  output logic [1:0]       out_nur_class,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t st;
  logic       cfg_we;

  // config beat taken only when idle
  assign cfg_we = cfg_valid && cfg_ready;

  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .st        (st)
  );

  ffa_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_process_id     (in_process_id),
    .in_request_size   (in_request_size),
    .in_referenced     (in_referenced),
    .in_modified       (in_modified),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_status        (out_status),
    .out_result_id     (out_result_id),
    .out_start_address (out_start_address),
    .out_nur_class     (out_nur_class),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the first-fit allocator with nur eviction: a
// scoreboard keeps its own block table, predicts every result beat and
// compares the beats coming back; random bursts, stalls and register phases
// ----------------------------------------------------------------------------
module tb;
  import ffa_pkg::*;

  localparam int TBL_DEPTH   = 32;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int SETTLE      = 40;

  // one predicted result beat
  typedef struct {
    status_t     st;
    logic [7:0]  id;
    logic [15:0] addr;
    logic [1:0]  cls;
    logic        last;
  } beat_t;

  // one entry of the predicted block table
  typedef struct {
    logic [15:0] start;
    logic [15:0] size;
    logic        used;
    logic [7:0]  pid;
    logic        r;
    logic        m;
    logic [15:0] mtime;
  } blk_t;

  class alloc_scoreboard;
    blk_t        tbl[TBL_DEPTH];
    int          cnt;
    logic [15:0] now;
    logic [7:0]  phase;
    logic [15:0] mem_size;
    logic [7:0]  period;
    beat_t       pending_beats[$];
    int          errors;

    function void reset_all();
      mem_size = MEM_SIZE_RST;
      period   = PERIOD_RST;
      now      = '0;
      phase    = '0;
      errors   = 0;
      pending_beats.delete();
      clear_table();
    endfunction

    function void clear_table();
      foreach (tbl[i]) tbl[i] = '{default: '0};
      tbl[0].size = mem_size;
      cnt = 1;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [15:0] data);
      if (idx == CFG_MEM_SIZE) begin
        mem_size = data;
        clear_table();
      end else begin
        period = data[7:0];
      end
    endfunction

    function logic [1:0] cls_of(int i);
      return {tbl[i].r, tbl[i].m};
    endfunction

    function void push(status_t st, logic [7:0] id, logic [15:0] addr,
                       logic [1:0] cls, logic last);
      beat_t b;
      b.st = st; b.id = id; b.addr = addr; b.cls = cls; b.last = last;
      pending_beats.push_back(b);
    endfunction

    function void remove_at(int idx);
      for (int i = idx; i + 1 < cnt; i++) tbl[i] = tbl[i + 1];
      cnt--;
    endfunction

    // release an evicted block and fold in free neighbours
    function void release_blk(int idx);
      int j;
      j = idx;
      tbl[j].used = 0; tbl[j].pid = '0; tbl[j].r = 0; tbl[j].m = 0;
      tbl[j].mtime = '0;
      if (j > 0 && !tbl[j - 1].used) begin
        tbl[j - 1].size += tbl[j].size;
        remove_at(j);
        j--;
      end
      if (j + 1 < cnt && !tbl[j + 1].used) begin
        tbl[j].size += tbl[j + 1].size;
        remove_at(j + 1);
      end
    endfunction

    function void predict_alloc(logic [7:0] pid, logic [15:0] req);
      int  hit;
      bit  done;
      if (req == 0) begin
        push(ST_NO_SPACE, pid, '0, '0, 1'b1);
        return;
      end
      done = 0;
      while (!done) begin
        hit = -1;
        for (int i = 0; i < cnt && hit < 0; i++)
          if (!tbl[i].used && tbl[i].size >= req) hit = i;
        if (hit >= 0) begin
          if (tbl[hit].size > req) begin
            if (cnt >= TBL_DEPTH) begin
              push(ST_TABLE_FULL, pid, '0, '0, 1'b1);
              return;
            end
            for (int c = cnt; c > hit + 1; c--) tbl[c] = tbl[c - 1];
            cnt++;
            tbl[hit + 1]       = '{default: '0};
            tbl[hit + 1].start = tbl[hit].start + req;
            tbl[hit + 1].size  = tbl[hit].size - req;
            tbl[hit].size      = req;
          end
          tbl[hit].used = 1; tbl[hit].pid = pid;
          tbl[hit].r = 1; tbl[hit].m = 1; tbl[hit].mtime = now;
          push(ST_PLACED, pid, tbl[hit].start, CLS_OWNED, 1'b1);
          done = 1;
        end else begin
          // victim: first resident block of the lowest class
          for (int c = 0; c < 4 && hit < 0; c++)
            for (int i = 0; i < cnt && hit < 0; i++)
              if (tbl[i].used && cls_of(i) == c) hit = i;
          if (hit < 0) begin
            push(ST_NO_SPACE, pid, '0, '0, 1'b1);
            done = 1;
          end else begin
            push(ST_EVICTED, tbl[hit].pid, tbl[hit].start, cls_of(hit), 1'b0);
            release_blk(hit);
          end
        end
      end
    endfunction

    function void predict_ref(logic [7:0] pid, logic rf, logic md);
      for (int i = 0; i < cnt; i++) begin
        if (tbl[i].used && tbl[i].pid == pid) begin
          if (rf) tbl[i].r = 1;
          if (md && !tbl[i].m) begin
            tbl[i].m = 1;
            tbl[i].mtime = now;
          end
          push(ST_REF_DONE, pid, tbl[i].start, cls_of(i), 1'b1);
          return;
        end
      end
      push(ST_NOT_RES, pid, '0, '0, 1'b1);
    endfunction

    function void predict_tick();
      logic [15:0] age;
      now   = now + 16'd1;
      phase = phase + 8'd1;
      if (phase >= period) begin
        phase = '0;
        for (int i = 0; i < cnt; i++) begin
          if (tbl[i].used) begin
            age = now - tbl[i].mtime;
            tbl[i].r = 0;
            if (tbl[i].m && age >= {8'd0, period}) tbl[i].m = 0;
          end
        end
      end
      push(ST_TICK_DONE, '0, '0, '0, 1'b1);
    endfunction

    function void note_item(opcode_t op, logic [7:0] pid, logic [15:0] req,
                            logic rf, logic md);
      case (op)
        OPC_ALLOC: predict_alloc(pid, req);
        OPC_REF:   predict_ref(pid, rf, md);
        OPC_TICK:  predict_tick();
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [7:0] id, logic [15:0] addr,
                               logic [1:0] cls, logic last);
      beat_t e;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat status=%0d id=%0d addr=%0d", $time, st, id, addr);
        errors++;
        return;
      end
      e = pending_beats.pop_front();
      if (st !== e.st) begin
        $display("%0t: status exp %0d got %0d", $time, e.st, st); errors++;
      end
      if (id !== e.id) begin
        $display("%0t: result_id exp %0d got %0d", $time, e.id, id); errors++;
      end
      if (addr !== e.addr) begin
        $display("%0t: start_address exp %0d got %0d", $time, e.addr, addr); errors++;
      end
      if (cls !== e.cls) begin
        $display("%0t: nur_class exp %0d got %0d", $time, e.cls, cls); errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last exp %0b got %0b", $time, e.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [7:0]  in_process_id;
  logic [15:0] in_request_size;
  logic        in_referenced;
  logic        in_modified;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [7:0]  out_result_id;
  logic [15:0] out_start_address;
  logic [1:0]  out_nur_class;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  alloc_scoreboard sb;
  int  cycles;
  bit  hold_off_req;
  bit  stimulus_done;

  first_fit_allocator_nur_eviction dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_process_id, .in_request_size,
    .in_referenced, .in_modified,
    .out_valid, .out_ready, .out_status, .out_result_id, .out_start_address,
    .out_nur_class, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: note accepted input beats, then check result beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_item(opcode_t'(in_opcode), in_process_id, in_request_size,
                     in_referenced, in_modified);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_result_id, out_start_address,
                        out_nur_class, out_last);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin
    int mode;
    int stretch;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (600) @(negedge clk);
        hold_off_req = 0;
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(5, 60);
      repeat (stretch) begin
        @(negedge clk);
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = ($urandom_range(0, 1) == 1);
          2:       out_ready = ($urandom_range(0, 4) == 0);
          default: out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // drive one input beat; returns at the falling edge after acceptance
  task automatic send_item(opcode_t op, logic [7:0] pid, logic [15:0] req,
                           logic rf, logic md);
    in_valid        = 1'b1;
    in_opcode       = op;
    in_process_id   = pid;
    in_request_size = req;
    in_referenced   = rf;
    in_modified     = md;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_valid = 1'b0;
  endtask

  // wait until every predicted beat has come back, then let the block settle
  task automatic drain();
    idle_input();
    while (sb.pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item(output opcode_t op, output logic [7:0] pid,
                             output logic [15:0] req);
    int sel;
    int top;
    sel = $urandom_range(0, 99);
    top = (sb.mem_size > 3) ? sb.mem_size / 3 : 1;
    if (sel < 45)      op = OPC_ALLOC;
    else if (sel < 72) op = OPC_REF;
    else if (sel < 96) op = OPC_TICK;
    else               op = OPC_RSVD;
    // mostly a small pool of ids so references find residents
    pid = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 11))
                                     : 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 75)      req = 16'($urandom_range(1, top));
    else if (sel < 88) req = 16'($urandom_range(1, (sb.mem_size > 0) ? sb.mem_size : 1));
    else if (sel < 98) req = 16'($urandom_range(1, 65535));
    else               req = '0;
  endtask

  // random beats in bursts with random gaps
  task automatic random_phase(int n_items, bit long_hold, bit mid_drain);
    opcode_t     op;
    logic [7:0]  pid;
    logic [15:0] req;
    int          sent;
    int          burst;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < n_items) begin
          random_item(op, pid, req);
          send_item(op, pid, req, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          if (op != OPC_RSVD) sent++;
          if (long_hold && sent == 10) hold_off_req = 1;
          if (mid_drain && sent == n_items / 2) drain();
        end
      end
      idle_input();
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
  endtask

  initial begin
    sb = new();
    sb.reset_all();
    cycles          = 0;
    hold_off_req    = 0;
    stimulus_done   = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_opcode       = OPC_TICK;
    in_process_id   = '0;
    in_request_size = '0;
    in_referenced   = 1'b0;
    in_modified     = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_MEM_SIZE;
    cfg_data        = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset settings, extremes and the special cases
    send_item(OPC_ALLOC, 8'd255, 16'hFFFF, 1'b0, 1'b0); // nothing resident
    send_item(OPC_ALLOC, 8'd3, 16'd0, 1'b0, 1'b0);      // zero size
    send_item(OPC_ALLOC, 8'd0, 16'd1, 1'b0, 1'b0);
    send_item(OPC_ALLOC, 8'd255, 16'd1023, 1'b1, 1'b1); // exact fit, no split
    send_item(OPC_REF, 8'd0, 16'd0, 1'b0, 1'b0);
    send_item(OPC_REF, 8'd7, 16'd0, 1'b1, 1'b1);        // not resident
    send_item(OPC_RSVD, 8'hAA, 16'h5555, 1'b1, 1'b1);   // ignored
    send_item(OPC_ALLOC, 8'd9, 16'd512, 1'b0, 1'b0);    // evicts both
    send_item(OPC_ALLOC, 8'd9, 16'd100, 1'b0, 1'b0);    // duplicate id
    repeat (10) send_item(OPC_TICK, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
    send_item(OPC_REF, 8'd9, 16'd0, 1'b0, 1'b1);        // m set only on change
    send_item(OPC_REF, 8'd9, 16'd0, 1'b1, 1'b0);
    send_item(OPC_ALLOC, 8'd1, 16'd600, 1'b0, 1'b0);    // lowest class first
    drain();

    // register phases, extremes among them
    write_reg(CFG_MEM_SIZE, 16'd64);
    write_reg(CFG_CLOCK_PERIOD, 16'd3);
    random_phase(90, 1'b1, 1'b0);
    drain();
    write_reg(CFG_MEM_SIZE, 16'd1);
    write_reg(CFG_CLOCK_PERIOD, 16'd1);
    random_phase(50, 1'b0, 1'b0);
    drain();
    write_reg(CFG_MEM_SIZE, 16'd65535);
    write_reg(CFG_CLOCK_PERIOD, 16'd255);
    random_phase(90, 1'b0, 1'b1);
    drain();
    write_reg(CFG_CLOCK_PERIOD, 16'd0);                 // sweep on every tick
    write_reg(CFG_MEM_SIZE, 16'd40);
    random_phase(80, 1'b0, 1'b0);
    drain();
    write_reg(CFG_MEM_SIZE, 16'd200);
    write_reg(CFG_CLOCK_PERIOD, 16'd2);
    random_phase(80, 1'b0, 1'b0);
    drain();
    write_reg(CFG_MEM_SIZE, 16'd1024);
    write_reg(CFG_CLOCK_PERIOD, 16'd10);
    random_phase(70, 1'b0, 1'b0);
    drain();

    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/ffa_pkg.sv
rtl/ffa_dp.sv
rtl/ffa_ctrl.sv
rtl/first_fit_allocator_nur_eviction.sv
tb/tb.sv
